@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by disk_point_sampler.
// Depends on nothing; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_HOLDS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define AST_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define AST_HOLDS(lbl, clk, rstn, expr)
`define AST_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/dps_pkg.sv @@
// Types, constants and helpers for the disk point sampler.
// No dependencies.
package dps_pkg;

  localparam int UB       = 16;  // variate width
  localparam int CW       = 34;  // CORDIC x/y width, Q.30
  localparam int ZW       = 33;  // CORDIC angle width, 2^-32 turn
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 8;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12e4051e, 32'h09fb385b, 32'h051111d4, 32'h028b0d43, 32'h0145d7e1,
    32'h00a2f61e, 32'h00517c55, 32'h0028be53, 32'h00145f2f, 32'h000a2f98, 32'h000517cc,
    32'h00028be6, 32'h000145f3, 32'h0000a2fa, 32'h0000517d, 32'h000028be, 32'h0000145f,
    32'h00000a30, 32'h00000518, 32'h0000028c, 32'h00000146, 32'h000000a3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000a, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [2:0] {
    REG_AXIS_A_X, REG_AXIS_A_Y, REG_AXIS_B_X, REG_AXIS_B_Y,
    REG_AXIS_B_Z, REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z
  } reg_idx_e;

  typedef struct packed {
    logic [UB-1:0] radial_uniform;
    logic [UB-1:0] angle_uniform;
  } dps_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } dps_out_t;

  typedef struct packed {
    logic signed [31:0] axis_a_x;
    logic signed [31:0] axis_a_y;
    logic signed [31:0] axis_b_x;
    logic signed [31:0] axis_b_y;
    logic signed [31:0] axis_b_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } dps_cfg_t;

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/dps_sqrt_cell.sv @@
// One digit of the pipelined integer square root.
// Depends on dps_pkg.
module dps_sqrt_cell import dps_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [UB+1:0] rem_i,
  input  logic [UB-1:0] root_i,
  input  logic [UB-1:0] rad_i,
  input  logic [UB-1:0] ang_i,
  output logic          valid_o,
  output logic [UB+1:0] rem_o,
  output logic [UB-1:0] root_o,
  output logic [UB-1:0] rad_o,
  output logic [UB-1:0] ang_o
);

  localparam int POS = 2*UB - 1 - 2*STEP;

  logic [2*UB-1:0] nfull;
  logic [UB+3:0]   cur, trial;
  logic            take;
  logic            valid_q;
  logic [UB+1:0]   rem_q, rem_d;
  logic [UB-1:0]   root_q, root_d, rad_q, ang_q;

  always_comb begin
    nfull  = {rad_i, {UB{1'b0}}};
    cur    = {rem_i, nfull[POS -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    take   = (cur >= trial);
    rem_d  = take ? (UB+2)'(cur - trial) : cur[UB+1:0];
    root_d = {root_i[UB-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_i;
      ang_q  <= ang_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign ang_o   = ang_q;

endmodule

@@ hw/rtl/dps_cordic_cell.sv @@
// One rotation-mode CORDIC stage.
// Depends on dps_pkg.
module dps_cordic_cell import dps_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic [UB-1:0]        s_i,
  input  logic                 flip_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic [UB-1:0]        s_o,
  output logic                 flip_o
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[STAGE]);

  logic signed [CW-1:0] xs, ys, x_d, y_d;
  logic signed [ZW-1:0] z_d;
  logic                 valid_q, flip_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [UB-1:0]        s_q;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!z_i[ZW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      s_q    <= s_i;
      flip_q <= flip_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign s_o     = s_q;
  assign flip_o  = flip_q;

endmodule

@@ hw/rtl/dps_scale.sv @@
// Radius scaling, axis projection, center offset and saturation; three stages.
// Depends on dps_pkg.
module dps_scale import dps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [UB-1:0]        s_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic                 flip_i,
  input  dps_cfg_t             cfg_i,
  output logic                 valid_o,
  output dps_out_t             point_o
);

  localparam int PW = UB + 1 + CW;
  localparam logic signed [PW-1:0] HALF_S = PW'(1) <<< (UB - 1);
  localparam logic signed [64:0]   HALF_P = 65'sd536870912;

  logic signed [CW-1:0] xf, yf;
  logic                 v1_q, v2_q, v3_q;
  logic signed [PW-1:0] pc_q, ps_q, pcr, psr;
  logic signed [31:0]   rc, rs;
  logic signed [63:0]   ax_q, ay_q, bx_q, by_q, bz_q;
  logic signed [64:0]   sx, sy, sz;
  logic signed [34:0]   tx, ty, tz;
  dps_out_t             pt_d, pt_q;

  always_comb begin
    xf  = flip_i ? -x_i : x_i;
    yf  = flip_i ? -y_i : y_i;
    pcr = (pc_q + HALF_S) >>> UB;
    psr = (ps_q + HALF_S) >>> UB;
    rc  = pcr[31:0];
    rs  = psr[31:0];
    sx  = ((65)'(ax_q) + (65)'(bx_q) + HALF_P) >>> 30;
    sy  = ((65)'(ay_q) + (65)'(by_q) + HALF_P) >>> 30;
    sz  = ((65)'(bz_q) + HALF_P) >>> 30;
    tx  = sx[34:0];
    ty  = sy[34:0];
    tz  = sz[34:0];
    pt_d.point_x = sat36(36'(cfg_i.center_x) + 36'(tx));
    pt_d.point_y = sat36(36'(cfg_i.center_y) + 36'(ty));
    pt_d.point_z = sat36(36'(cfg_i.center_z) + 36'(tz));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q <= $signed({1'b0, s_i}) * xf;
      ps_q <= $signed({1'b0, s_i}) * yf;
      ax_q <= rc * cfg_i.axis_a_x;
      ay_q <= rc * cfg_i.axis_a_y;
      bx_q <= rs * cfg_i.axis_b_x;
      by_q <= rs * cfg_i.axis_b_y;
      bz_q <= rs * cfg_i.axis_b_z;
      pt_q <= pt_d;
    end
  end

  assign valid_o = v3_q;
  assign point_o = pt_q;

endmodule

@@ hw/rtl/disk_point_sampler.sv @@
// Disk point sampler: maps a pair of uniform variates to a point spread uniformly
// over a disk in 3D. One beat is accepted every cycle while the output is not
// held; each beat passes one square-root cell per root bit, one CORDIC cell
// per stage and three scaling stages. A held output stalls the whole chain.
// Users must write registers through the cfg port while idle (not enforced).
// Depends on dps_pkg, the cell modules, dps_scale and assert_macros.svh.
`include "assert_macros.svh"
module disk_point_sampler import dps_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dps_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dps_out_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  logic     en;
  dps_cfg_t cfg_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i[IDX_W-1:3] == '0)) begin
      unique case (reg_idx_e'(cfg_index_i[2:0]))
        REG_AXIS_A_X: cfg_q.axis_a_x <= cfg_data_i;
        REG_AXIS_A_Y: cfg_q.axis_a_y <= cfg_data_i;
        REG_AXIS_B_X: cfg_q.axis_b_x <= cfg_data_i;
        REG_AXIS_B_Y: cfg_q.axis_b_y <= cfg_data_i;
        REG_AXIS_B_Z: cfg_q.axis_b_z <= cfg_data_i;
        REG_CENTER_X: cfg_q.center_x <= cfg_data_i;
        REG_CENTER_Y: cfg_q.center_y <= cfg_data_i;
        REG_CENTER_Z: cfg_q.center_z <= cfg_data_i;
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  // square-root chain
  logic          sq_v    [UB+1];
  logic [UB+1:0] sq_rem  [UB+1];
  logic [UB-1:0] sq_root [UB+1];
  logic [UB-1:0] sq_rad  [UB+1];
  logic [UB-1:0] sq_ang  [UB+1];

  assign sq_v[0]    = in_valid_i;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = in_data_i.radial_uniform;
  assign sq_ang[0]  = in_data_i.angle_uniform;

  for (genvar k = 0; k < UB; k++) begin : g_sqrt
    dps_sqrt_cell #(.STEP(k)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sq_v[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]),
      .rad_i(sq_rad[k]), .ang_i(sq_ang[k]),
      .valid_o(sq_v[k+1]), .rem_o(sq_rem[k+1]), .root_o(sq_root[k+1]),
      .rad_o(sq_rad[k+1]), .ang_o(sq_ang[k+1])
    );
  end

  // quadrant fold: second and third quarter turns rotate by a half turn
  logic [31:0] phase, phase_f;
  logic        flip0;

  always_comb begin
    phase   = 32'(sq_ang[UB]) << (32 - UB);
    flip0   = phase[31] ^ phase[30];
    phase_f = flip0 ? (phase - 32'h80000000) : phase;
  end

  logic                 co_v    [NST+1];
  logic signed [CW-1:0] co_x    [NST+1];
  logic signed [CW-1:0] co_y    [NST+1];
  logic signed [ZW-1:0] co_z    [NST+1];
  logic [UB-1:0]        co_s    [NST+1];
  logic                 co_flip [NST+1];

  assign co_v[0]    = sq_v[UB];
  assign co_x[0]    = CORDIC_GAIN;
  assign co_y[0]    = '0;
  assign co_z[0]    = {phase_f[31], phase_f};
  assign co_s[0]    = sq_root[UB];
  assign co_flip[0] = flip0;

  for (genvar i = 0; i < NST; i++) begin : g_cordic
    dps_cordic_cell #(.STAGE(i)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(co_v[i]), .x_i(co_x[i]), .y_i(co_y[i]), .z_i(co_z[i]),
      .s_i(co_s[i]), .flip_i(co_flip[i]),
      .valid_o(co_v[i+1]), .x_o(co_x[i+1]), .y_o(co_y[i+1]), .z_o(co_z[i+1]),
      .s_o(co_s[i+1]), .flip_o(co_flip[i+1])
    );
  end

  dps_scale u_scale (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(co_v[NST]), .s_i(co_s[NST]), .x_i(co_x[NST]), .y_i(co_y[NST]),
    .flip_i(co_flip[NST]), .cfg_i(cfg_q),
    .valid_o(out_valid_o), .point_o(out_data_o)
  );

  `AST_IMPLIES(a_stall_only_on_held_beat, clk_i, rst_ni, !in_ready_o,
               out_valid_o && !out_ready_i)
  `AST_HOLDS(a_valid_rises_on_advance, clk_i, rst_ni,
             !$rose(out_valid_o) || $past(in_ready_o))

endmodule

@@ sim/disk_point_sampler_tb.sv @@
// Testbench for disk_point_sampler: random and directed variate beats with a bit-exact
// predictor of the root, CORDIC and scaling path, checked against each output beat.
// Depends on dps_pkg and the disk_point_sampler RTL.
`timescale 1ns / 100ps
module disk_point_sampler_tb;
  import dps_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = UB + STAGES + 3;
  localparam int WATCHDOG = 2000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  dps_in_t in_data;
  dps_out_t out_data;
  logic [IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  disk_point_sampler #(.CORDIC_STAGES(STAGES)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  dps_cfg_t disk_cfg;
  dps_in_t variate_q[$];
  dps_out_t point_q[$];
  int errors, wait_cnt, stall_cnt, idle_cycles, beats_in, beats_out, cfg_sets;
  logic cfg_busy;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] round_sh(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic dps_out_t sample_point(input dps_in_t v, input dps_cfg_t c);
    logic [31:0] rem, root, bitv, phase;
    logic signed [63:0] x, y, z, xs, ys, rc, rs, s;
    logic flip;
    dps_out_t p;
    rem = {v.radial_uniform, 16'h0};
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    phase = {v.angle_uniform, 16'h0};
    flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    if (flip) phase = phase - 32'h8000_0000;
    z = 64'(signed'(phase));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - 64'(ATAN_TAB[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + 64'(ATAN_TAB[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = 64'(root);
    rc = round_sh(s * x, UB);
    rs = round_sh(s * y, UB);
    p.point_x = clamp32(64'(c.center_x) + round_sh(rc * 64'(c.axis_a_x)
                + rs * 64'(c.axis_b_x), 30));
    p.point_y = clamp32(64'(c.center_y) + round_sh(rc * 64'(c.axis_a_y)
                + rs * 64'(c.axis_b_y), 30));
    p.point_z = clamp32(64'(c.center_z) + round_sh(rs * 64'(c.axis_b_z), 30));
    return p;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      wait_cnt <= 0;
    end else if (in_valid && !in_ready) begin
    end else if (wait_cnt > 0) begin
      in_valid <= 1'b0;
      wait_cnt <= wait_cnt - 1;
    end else if (variate_q.size() > 0) begin
      in_valid <= 1'b1;
      in_data <= variate_q.pop_front();
      wait_cnt <= $urandom_range(0, 8) * ($urandom_range(0, 3) == 0);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // expected points follow the config at acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      point_q.push_back(sample_point(in_data, disk_cfg));
      beats_in++;
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (point_q.size() == 0) begin
          $error("unexpected point beat %h", out_data);
          errors++;
        end else begin
          dps_out_t e;
          e = point_q.pop_front();
          if (out_data.point_x !== e.point_x) begin
            $error("point_x expected %0d actual %0d", e.point_x, out_data.point_x);
            errors++;
          end
          if (out_data.point_y !== e.point_y) begin
            $error("point_y expected %0d actual %0d", e.point_y, out_data.point_y);
            errors++;
          end
          if (out_data.point_z !== e.point_z) begin
            $error("point_z expected %0d actual %0d", e.point_z, out_data.point_z);
            errors++;
          end
        end
      end
      if (stall_cnt > 0) begin
        out_ready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && $urandom_range(0, 3) == 0) stall_cnt <= $urandom_range(0, 8);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("disk_point_sampler test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= IDX_W'(idx);
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AXIS_A_X: disk_cfg.axis_a_x = val;
      REG_AXIS_A_Y: disk_cfg.axis_a_y = val;
      REG_AXIS_B_X: disk_cfg.axis_b_x = val;
      REG_AXIS_B_Y: disk_cfg.axis_b_y = val;
      REG_AXIS_B_Z: disk_cfg.axis_b_z = val;
      REG_CENTER_X: disk_cfg.center_x = val;
      REG_CENTER_Y: disk_cfg.center_y = val;
      default: disk_cfg.center_z = val;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // checked at the falling edge so the driver and monitor updates have settled
  task automatic drain;
    while (variate_q.size() > 0 || point_q.size() > 0 || in_valid) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mode 0: small sane disk, 1: extremes, 2: fully random
  task automatic load_cfg(input int mode);
    logic [31:0] v;
    cfg_sets++;
    for (int r = 0; r < NUM_REGS; r++) begin
      case (mode)
        0: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        1: v = ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
        default: v = $urandom;
      endcase
      write_reg(reg_idx_e'(r), v);
    end
  endtask

  function automatic dps_in_t mk(input logic [15:0] r, input logic [15:0] a);
    dps_in_t v;
    v.radial_uniform = r;
    v.angle_uniform = a;
    return v;
  endfunction

  initial begin
    logic [15:0] edge_val[6];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    disk_cfg = '0;
    errors = 0; beats_in = 0; beats_out = 0; cfg_sets = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    variate_q.push_back(mk(16'hffff, 16'h1234));
    drain();
    load_cfg(0);
    edge_val = '{16'h0000, 16'hffff, 16'h4000, 16'h8000, 16'hc000, 16'h3fff};
    foreach (edge_val[i]) begin
      variate_q.push_back(mk(edge_val[i], edge_val[(i + 1) % 6]));
      variate_q.push_back(mk(edge_val[(i + 3) % 6], edge_val[i]));
    end
    variate_q.push_back(mk(16'h0000, 16'h5555));
    variate_q.push_back(mk(16'h0001, 16'h7fff));
    variate_q.push_back(mk(16'h8000, 16'hbfff));
    drain();
    load_cfg(1);
    variate_q.push_back(mk(16'hffff, 16'h0000));
    variate_q.push_back(mk(16'hffff, 16'h8000));
    variate_q.push_back(mk(16'h0000, 16'h0000));
    variate_q.push_back(mk(16'hffff, 16'h2000));
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      load_cfg(ph == 3 ? 1 : (ph % 2 ? 2 : 0));
      for (int n = 0; n < 200; n++) variate_q.push_back(mk($urandom, $urandom));
      drain();
    end
    while (point_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d variate pairs, checked %0d points across %0d register settings.",
             beats_in, beats_out, cfg_sets);
    if (errors == 0 && point_q.size() == 0) begin
      $display("disk_point_sampler test passed");
    end else begin
      $display("disk_point_sampler test failed");
    end
    $finish;
  end

endmodule
